// File: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
// Each macro takes a label, an antecedent and a consequent, and runs on clk
// with rst as the disable condition.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/mrtf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrtf_pkg
// Types, codes and the CRC-16 step shared by the RTU-to-TCP framer.
// ----------------------------------------------------------------------------
package mrtf_pkg;

  // Input operation codes; code 3 is unused
  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_READ = 2'd2
  } opcode_t;

  // Receiver phase, one-hot
  typedef enum logic [3:0] {
    PH_INIT = 4'b0001,
    PH_IDLE = 4'b0010,
    PH_RCV  = 4'b0100,
    PH_ERR  = 4'b1000
  } phase_t;

  // Phase codes as reported on rx_phase_out
  localparam logic [1:0] PHASE_CODE_INIT = 2'd0;
  localparam logic [1:0] PHASE_CODE_IDLE = 2'd1;
  localparam logic [1:0] PHASE_CODE_RCV  = 2'd2;
  localparam logic [1:0] PHASE_CODE_ERR  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_SILENCE  = 2'd0;
  localparam logic [1:0] CFG_TID_HIGH = 2'd1;
  localparam logic [1:0] CFG_TID_LOW  = 2'd2;

  localparam logic [15:0] SILENCE_RESET = 16'd35;
  localparam logic [15:0] SILENCE_MAX   = 16'hFFFF;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [8:0]  MIN_FRAME     = 9'd4;
  localparam logic [8:0]  HDR_LAST      = 9'd6;   // index of unit address byte

  // Result of one item as it leaves the control stage
  typedef struct packed {
    logic       from_mem;
    logic [7:0] hdr_byte;
    logic       out_valid;
    logic       out_last;
    logic       frame_ready;
    logic       frame_dropped;
    logic       overrun;
    logic [1:0] rx_phase;
  } result_t;

  function automatic logic [1:0] phase_code(phase_t p);
    logic [1:0] c;
    unique case (p)
      PH_INIT: c = PHASE_CODE_INIT;
      PH_IDLE: c = PHASE_CODE_IDLE;
      PH_RCV:  c = PHASE_CODE_RCV;
      PH_ERR:  c = PHASE_CODE_ERR;
      default: c = PHASE_CODE_INIT;
    endcase
    return c;
  endfunction

  // Modbus CRC-16, reflected, one byte
  function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/mrtf_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrtf_store
// Frame byte store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mrtf_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/mrtf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrtf_ctrl
// RTU receive phases, silence timer, CRC, read sequencing and config regs.
// Updates the receive and read state on the cycle a word is accepted and issues
// the store access for it.
// ----------------------------------------------------------------------------
module mrtf_ctrl #(
  parameter int MAX_FRAME_BYTES = 256,
  parameter int AW              = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [1:0]          opcode,
  input  logic [7:0]          rx_byte,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output logic [7:0]          mem_wdata,
  output logic                mem_re,
  output logic [AW-1:0]       mem_raddr,
  output mrtf_pkg::result_t   res
);

  localparam logic [8:0] MaxCount = 9'(MAX_FRAME_BYTES);

  // state
  logic [8:0]        write_count, write_count_next;
  mrtf_pkg::phase_t  rx_phase, rx_phase_next;
  logic [15:0]       silence_count, silence_count_next;
  logic              timer_running, timer_running_next;
  logic [15:0]       crc_running, crc_running_next;
  logic              frame_pending, frame_pending_next;
  logic [8:0]        read_index, read_index_next;

  // config
  logic [15:0] silence_ticks;
  logic [7:0]  trans_id_high;
  logic [7:0]  trans_id_low;

  // helpers
  logic [15:0] silence_inc;
  logic [8:0]  len_field;
  logic [8:0]  last_index;
  logic [8:0]  rel_index;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      silence_ticks <= mrtf_pkg::SILENCE_RESET;
      trans_id_high <= '0;
      trans_id_low  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mrtf_pkg::CFG_SILENCE:  silence_ticks <= cfg_data;
        mrtf_pkg::CFG_TID_HIGH: trans_id_high <= cfg_data[7:0];
        mrtf_pkg::CFG_TID_LOW:  trans_id_low  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign silence_inc = (silence_count < mrtf_pkg::SILENCE_MAX) ?
                       silence_count + 16'd1 : silence_count;
  assign len_field   = write_count - 9'd2;   // PDU length + unit byte
  assign last_index  = write_count + 9'd3;
  assign rel_index   = read_index - mrtf_pkg::HDR_LAST;

  // next state and store access for the accepted word
  always_comb begin
    write_count_next   = write_count;
    rx_phase_next      = rx_phase;
    silence_count_next = silence_count;
    timer_running_next = timer_running;
    crc_running_next   = crc_running;
    frame_pending_next = frame_pending;
    read_index_next    = read_index;
    mem_we             = 1'b0;
    mem_waddr          = write_count[AW-1:0];
    mem_wdata          = rx_byte;
    mem_re             = 1'b0;
    mem_raddr          = rel_index[AW-1:0];
    res                = '0;

    if (accept) begin
      unique case (mrtf_pkg::opcode_t'(opcode))
        mrtf_pkg::OP_BYTE: begin
          if (rx_phase == mrtf_pkg::PH_IDLE) begin
            // first byte of a frame; any pending frame is lost
            frame_pending_next = 1'b0;
            read_index_next    = '0;
            mem_we             = 1'b1;
            mem_waddr          = '0;
            write_count_next   = 9'd1;
            crc_running_next   = mrtf_pkg::crc_update(mrtf_pkg::CRC_INIT, rx_byte);
            rx_phase_next      = mrtf_pkg::PH_RCV;
          end else if (rx_phase == mrtf_pkg::PH_RCV) begin
            if (write_count < MaxCount) begin
              mem_we           = 1'b1;
              write_count_next = write_count + 9'd1;
              crc_running_next = mrtf_pkg::crc_update(crc_running, rx_byte);
            end else begin
              rx_phase_next = mrtf_pkg::PH_ERR;
              res.overrun   = 1'b1;
            end
          end
          silence_count_next = '0;
          timer_running_next = 1'b1;
        end
        mrtf_pkg::OP_TICK: begin
          if (timer_running) begin
            silence_count_next = silence_inc;
            if (silence_inc >= silence_ticks) begin
              timer_running_next = 1'b0;
              if (rx_phase == mrtf_pkg::PH_RCV) begin
                // end of frame: length and CRC check
                if (write_count >= mrtf_pkg::MIN_FRAME && crc_running == 16'd0) begin
                  frame_pending_next = 1'b1;
                  read_index_next    = '0;
                end else begin
                  res.frame_dropped = 1'b1;
                end
                rx_phase_next = mrtf_pkg::PH_IDLE;
              end else if (rx_phase == mrtf_pkg::PH_INIT ||
                           rx_phase == mrtf_pkg::PH_ERR) begin
                rx_phase_next = mrtf_pkg::PH_IDLE;
              end
            end
          end
        end
        mrtf_pkg::OP_READ: begin
          if (frame_pending) begin
            res.out_valid = 1'b1;
            // header bytes come from here, payload from the store
            unique case (read_index)
              9'd0:    res.hdr_byte = trans_id_high;
              9'd1:    res.hdr_byte = trans_id_low;
              9'd4:    res.hdr_byte = {7'd0, len_field[8]};
              9'd5:    res.hdr_byte = len_field[7:0];
              default: res.hdr_byte = '0;
            endcase
            res.from_mem = (read_index >= mrtf_pkg::HDR_LAST);
            mem_re       = res.from_mem;
            if (read_index >= last_index) begin
              res.out_last       = 1'b1;
              frame_pending_next = 1'b0;
              read_index_next    = '0;
            end else begin
              read_index_next = read_index + 9'd1;
            end
          end
        end
        default: ;
      endcase
    end

    res.frame_ready = frame_pending_next;
    res.rx_phase    = mrtf_pkg::phase_code(rx_phase_next);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      write_count   <= '0;
      rx_phase      <= mrtf_pkg::PH_INIT;
      silence_count <= '0;
      timer_running <= 1'b1;
      crc_running   <= mrtf_pkg::CRC_INIT;
      frame_pending <= 1'b0;
      read_index    <= '0;
    end else begin
      write_count   <= write_count_next;
      rx_phase      <= rx_phase_next;
      silence_count <= silence_count_next;
      timer_running <= timer_running_next;
      crc_running   <= crc_running_next;
      frame_pending <= frame_pending_next;
      read_index    <= read_index_next;
    end
  end

endmodule

// File: hw/rtl/mrtf_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrtf_out
// Result pipeline: a stage that waits for store read data, then the output
// register. Either side may stall without losing a word.
// ----------------------------------------------------------------------------
module mrtf_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  mrtf_pkg::result_t res_in,
  input  logic [7:0]        rdata,
  output logic              in_stall,
  output logic              res_valid,
  input  logic              res_stall,
  output logic [7:0]        out_byte,
  output logic              out_valid,
  output logic              out_last,
  output logic              frame_ready,
  output logic              frame_dropped,
  output logic              overrun,
  output logic [1:0]        rx_phase_out
);

  logic              s2_valid;
  mrtf_pkg::result_t s2;
  logic              s2_move;

  assign s2_move  = s2_valid && (!res_valid || !res_stall);
  assign in_stall = s2_valid && !s2_move;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        s2_valid <= 1'b1;
      end else if (s2_move) begin
        s2_valid <= 1'b0;
      end
      if (s2_move) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload; store data is valid while s2 holds its word
  always_ff @(posedge clk) begin
    if (accept) begin
      s2 <= res_in;
    end
    if (s2_move) begin
      out_byte      <= s2.from_mem ? rdata : s2.hdr_byte;
      out_valid     <= s2.out_valid;
      out_last      <= s2.out_last;
      frame_ready   <= s2.frame_ready;
      frame_dropped <= s2.frame_dropped;
      overrun       <= s2.overrun;
      rx_phase_out  <= s2.rx_phase;
    end
  end

endmodule

// File: hw/rtl/modbus_rtu_to_tcp_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_to_tcp_framer
// Modbus RTU receiver that checks frames and reads them out as Modbus TCP.
// ----------------------------------------------------------------------------
// One word enters per cycle when the result side keeps up. Each word's result
// word is offered from the output register: the control stage and the
// registered read of the frame store share the accepting edge, and the
// output register loads when it is free. A stalled result holds the input
// off only while the stage behind it is also full. The frame store has one
// write and one read port; received bytes write it and reads of the payload
// read it. A payload read can never hit a byte written in the cycle before,
// since a frame is only offered after the closing tick, so no forwarding is
// needed. MAX_FRAME_BYTES sets the store depth and the overrun limit. The
// silence length (T3.5 in ticks) is set by software through register 0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module modbus_rtu_to_tcp_framer #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  rx_byte,
  // result words
  output logic        res_valid,
  input  logic        res_stall,
  output logic [7:0]  out_byte,
  output logic        out_valid,
  output logic        out_last,
  output logic        frame_ready,
  output logic        frame_dropped,
  output logic        overrun,
  output logic [1:0]  rx_phase_out,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AddrWidth = $clog2(MAX_FRAME_BYTES);

  logic                  accept;
  logic                  mem_we;
  logic [AddrWidth-1:0]  mem_waddr;
  logic [7:0]            mem_wdata;
  logic                  mem_re;
  logic [AddrWidth-1:0]  mem_raddr;
  logic [7:0]            mem_rdata;
  mrtf_pkg::result_t     res;

  assign accept = in_valid && !in_stall;

  mrtf_ctrl #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .AW              (AddrWidth)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .opcode    (opcode),
    .rx_byte   (rx_byte),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .res       (res)
  );

  mrtf_store #(
    .DEPTH (MAX_FRAME_BYTES),
    .AW    (AddrWidth)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mrtf_out u_out (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .res_in        (res),
    .rdata         (mem_rdata),
    .in_stall      (in_stall),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .out_byte      (out_byte),
    .out_valid     (out_valid),
    .out_last      (out_last),
    .frame_ready   (frame_ready),
    .frame_dropped (frame_dropped),
    .overrun       (overrun),
    .rx_phase_out  (rx_phase_out)
  );

  // a last byte is always real data and closes the pending frame
  `ASSERT_SAME(a_last_closes, res_valid && out_last, out_valid && !frame_ready)
  // overrun only happens together with the move to error
  `ASSERT_SAME(a_overrun_err, res_valid && overrun,
               rx_phase_out == mrtf_pkg::PHASE_CODE_ERR)
  // a dropped frame ends in idle with nothing pending
  `ASSERT_SAME(a_drop_idle, res_valid && frame_dropped,
               rx_phase_out == mrtf_pkg::PHASE_CODE_IDLE && !frame_ready)
  // a stalled result word stays put
  `ASSERT_NEXT(a_res_hold, res_valid && res_stall,
               res_valid && $stable({out_byte, out_valid, out_last, frame_ready,
                                     frame_dropped, overrun, rx_phase_out}))

endmodule
